// ===== rtl/core/pfe_pkg.sv =====
`timescale 1ns / 1ps
// Package for the postfix expression evaluator: token and result types,
// token class and status codes, and sizing constants. No dependencies.
package pfe_pkg;

	// Default number of values the evaluation stack holds
	localparam int DEF_STACK_DEPTH = 16;
	// Entries in the queue between token front end and stack engine
	localparam int QUEUE_DEPTH = 2;
	localparam int COUNT_W = 16;

	// Token kind codes
	localparam logic [1:0] KIND_NUM = 2'd0;
	localparam logic [1:0] KIND_OP  = 2'd1;
	localparam logic [1:0] KIND_BRK = 2'd2;

	// Operation codes
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_REM = 3'd4;

	// Classified token codes carried through the queue
	localparam logic [2:0] CL_NUM = 3'd0;
	localparam logic [2:0] CL_ADD = 3'd1;
	localparam logic [2:0] CL_SUB = 3'd2;
	localparam logic [2:0] CL_MUL = 3'd3;
	localparam logic [2:0] CL_DIV = 3'd4;
	localparam logic [2:0] CL_REM = 3'd5;
	localparam logic [2:0] CL_BRK = 3'd6;
	localparam logic [2:0] CL_NOP = 3'd7;

	// Result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_MISMATCH = 3'd1;
	localparam logic [2:0] ST_UNDERFLOW = 3'd2;
	localparam logic [2:0] ST_DIVZERO  = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [30:0] number_value;
		logic [2:0]  operation;
		logic        last_token;
	} token_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [2:0]         status;
	} result_t;

	// Classified token as queued for the stack engine
	typedef struct packed {
		logic [2:0]  cls;
		logic [30:0] num;
		logic        last;
		logic        mismatch;
	} tok_t;

	// Divider request and response
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
		logic [31:0] rem;
	} div_rsp_t;

endpackage

// ===== rtl/core/postfix_expression_evaluator_unit.sv =====
`timescale 1ns / 1ps
// A token is written into the queue when accepted and leaves it once the back end is idle; the back
// end handles a number or bracket in S_IDLE, add, subtract, multiply or a zero divisor via S_READ,
// and divide or remainder via S_READ and S_DIV (32 divider steps); S_FIN then issues the result.
// The back end takes no new token until it is through with the last one; queued tokens wait.
// Reset (arst_n low) empties the stack, count and error state at once; the stack
// RAM itself is not cleared, so no clearing pass is needed.
module postfix_expression_evaluator_unit #(
	parameter int STACK_DEPTH = pfe_pkg::DEF_STACK_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             token_valid,
	output logic             token_ready,
	input  pfe_pkg::token_t  token,
	output logic             result_valid,
	input  logic             result_ready,
	output pfe_pkg::result_t result
);
	import pfe_pkg::*;

	logic q_push;
	tok_t q_push_tok;
	logic q_full;
	logic q_pop;
	tok_t q_head;
	logic q_head_valid;

	pfe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token       (token),
		.q_full      (q_full),
		.push        (q_push),
		.push_tok    (q_push_tok)
	);

	pfe_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_tok   (q_push_tok),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.head_valid (q_head_valid)
	);

	pfe_back #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.head_valid   (q_head_valid),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== rtl/core/pfe_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/pfe_div.sv =====
`timescale 1ns / 1ps
// Iterative 32-bit signed divider, one quotient bit per cycle, truncating.
// Depends on pfe_pkg for the request and response structs.
module pfe_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pfe_pkg::div_req_t req,
	output pfe_pkg::div_rsp_t rsp
);
	import pfe_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] dvd_q;   // dividend bits shift out, quotient bits shift in
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic        neg_q_q;
	logic        neg_r_q;
	logic [32:0] rem_shift;
	logic [32:0] diff;

	// One restoring step
	assign rem_shift = {rem_q, dvd_q[31]};
	assign diff      = rem_shift - {1'b0, dvs_q};

	// Control: start, count 32 steps, pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == 5'd31);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: load magnitudes, then shift and subtract
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q   <= req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
			dvs_q   <= req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
			rem_q   <= '0;
			neg_q_q <= req.dividend[31] ^ req.divisor[31];
			neg_r_q <= req.dividend[31];
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
			end else begin
				rem_q <= rem_shift[31:0];
			end
			dvd_q <= {dvd_q[30:0], ~diff[32]};
		end
	end

	// Apply signs: quotient follows both operands, remainder the dividend
	assign rsp.done = done_q;
	assign rsp.quo  = neg_q_q ? (32'd0 - dvd_q) : dvd_q;
	assign rsp.rem  = neg_r_q ? (32'd0 - rem_q) : rem_q;

endmodule

// ===== rtl/core/pfe_fifo.sv =====
`timescale 1ns / 1ps
// Short queue of classified tokens between front end and stack engine.
// Depends on pfe_pkg for tok_t and QUEUE_DEPTH.
module pfe_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pfe_pkg::tok_t push_tok,
	output logic          full,
	input  logic          pop,
	output pfe_pkg::tok_t head,
	output logic          head_valid
);
	import pfe_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	tok_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == CW'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Hold queued tokens
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule

// ===== rtl/core/pfe_front.sv =====
`timescale 1ns / 1ps
// Token front end: accepts tokens, classifies them and tracks the
// number/operator count balance. Depends on pfe_pkg.
module pfe_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            token_valid,
	output logic            token_ready,
	input  pfe_pkg::token_t token,
	input  logic            q_full,
	output logic            push,
	output pfe_pkg::tok_t   push_tok
);
	import pfe_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_next;
	logic [2:0]         cls;

	assign token_ready = !q_full;
	assign push        = token_valid && token_ready;

	// Classify the token
	always_comb begin
		case (token.kind)
			KIND_NUM: cls = CL_NUM;
			KIND_OP: begin
				case (token.operation)
					OP_ADD:  cls = CL_ADD;
					OP_SUB:  cls = CL_SUB;
					OP_MUL:  cls = CL_MUL;
					OP_DIV:  cls = CL_DIV;
					OP_REM:  cls = CL_REM;
					default: cls = CL_NOP;
				endcase
			end
			KIND_BRK: cls = CL_BRK;
			default:  cls = CL_NOP;
		endcase
	end

	// Numbers count up, valid operators count down
	always_comb begin
		if (cls == CL_NUM) begin
			count_next = count_q + 1'b1;
		end else if (cls inside {[CL_ADD:CL_REM]}) begin
			count_next = count_q - 1'b1;
		end else begin
			count_next = count_q;
		end
	end

	assign push_tok.cls      = cls;
	assign push_tok.num      = token.number_value;
	assign push_tok.last     = token.last_token;
	assign push_tok.mismatch = (count_next != COUNT_W'(1));

	// Update balance, restart at the end of each expression
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= token.last_token ? '0 : count_next;
		end
	end

endmodule

// ===== rtl/core/pfe_back.sv =====
`timescale 1ns / 1ps
// Stack engine: executes queued tokens on the value stack and issues results.
// Depends on pfe_pkg, pfe_ram and pfe_div.
module pfe_back #(
	parameter int STACK_DEPTH = pfe_pkg::DEF_STACK_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pfe_pkg::tok_t    head,
	input  logic             head_valid,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_ready,
	output pfe_pkg::result_t result
);
	import pfe_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int LW = $clog2(STACK_DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]    state_q;
	logic [LW-1:0] level_q;
	logic [2:0]    err_q;
	logic [31:0]   top_q;     // top of stack lives here, the rest in RAM
	logic [2:0]    cls_q;
	logic          last_q;
	logic          mism_q;
	logic          out_valid_q;
	result_t       out_q;

	logic          ram_we;
	logic          ram_re;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;
	logic [LW-1:0] level_m1;
	logic [LW-1:0] level_m2;

	div_req_t      div_req;
	div_rsp_t      div_rsp;

	logic          err_ok;
	logic          stack_full;
	logic          below_two;
	logic          out_free;
	logic [31:0]   alu_res;
	logic [2:0]    fin_status;

	assign err_ok     = (err_q == ST_OK);
	assign stack_full = (level_q == LW'(STACK_DEPTH));
	assign below_two  = (level_q < LW'(2));
	assign out_free   = !out_valid_q || result_ready;
	assign level_m1   = level_q - 1'b1;
	assign level_m2   = level_q - LW'(2);
	assign ram_waddr  = level_m1[AW-1:0];
	assign ram_raddr  = level_m2[AW-1:0];
	assign pop        = (state_q == S_IDLE) && head_valid;

	// Spill old top on push, fetch left operand on operator
	always_comb begin
		ram_we = 1'b0;
		ram_re = 1'b0;
		if (pop && err_ok) begin
			if (head.cls == CL_NUM) begin
				ram_we = !stack_full && (level_q != '0);
			end else if (head.cls inside {[CL_ADD:CL_REM]}) begin
				ram_re = !below_two;
			end
		end
	end

	pfe_ram #(
		.WIDTH(32),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (top_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Divider is started once the left operand is read and the divisor is nonzero
	assign div_req.start    = (state_q == S_READ) && (cls_q inside {CL_DIV, CL_REM})
	                          && (top_q != '0);
	assign div_req.dividend = ram_rdata;
	assign div_req.divisor  = top_q;

	pfe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Add, subtract, multiply with wrap
	always_comb begin
		case (cls_q)
			CL_ADD:  alu_res = ram_rdata + top_q;
			CL_SUB:  alu_res = ram_rdata - top_q;
			CL_MUL:  alu_res = ram_rdata * top_q;
			default: alu_res = ram_rdata;
		endcase
	end

	// Final status: count mismatch wins, then first error, then empty stack
	always_comb begin
		if (mism_q) begin
			fin_status = ST_MISMATCH;
		end else if (!err_ok) begin
			fin_status = err_q;
		end else if (level_q == '0) begin
			fin_status = ST_UNDERFLOW;
		end else begin
			fin_status = ST_OK;
		end
	end

	// Sequence each token through the stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			level_q <= '0;
			err_q   <= ST_OK;
			cls_q   <= CL_NOP;
			last_q  <= 1'b0;
			mism_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						cls_q  <= head.cls;
						last_q <= head.last;
						mism_q <= head.mismatch;
						if (err_ok && (head.cls inside {[CL_ADD:CL_REM]}) && !below_two) begin
							state_q <= S_READ;
						end else begin
							state_q <= head.last ? S_FIN : S_IDLE;
						end
						if (err_ok) begin
							if (head.cls == CL_NUM) begin
								if (stack_full) begin
									err_q <= ST_OVERFLOW;
								end else begin
									level_q <= level_q + 1'b1;
								end
							end else if (head.cls == CL_BRK) begin
								if (below_two) begin
									err_q <= ST_UNDERFLOW;
								end
							end else if (head.cls inside {[CL_ADD:CL_REM]}) begin
								if (below_two) begin
									err_q <= ST_UNDERFLOW;
								end
							end
						end
					end
				end
				S_READ: begin
					if (cls_q inside {CL_DIV, CL_REM}) begin
						if (top_q == '0) begin
							err_q   <= ST_DIVZERO;
							state_q <= last_q ? S_FIN : S_IDLE;
						end else begin
							state_q <= S_DIV;
						end
					end else begin
						level_q <= level_m1;
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						level_q <= level_m1;
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					if (out_free) begin
						level_q <= '0;
						err_q   <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Raise result valid on issue, drop it once the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Top-of-stack and result payload
	always_ff @(posedge clk) begin
		if (pop && err_ok && head.cls == CL_NUM && !stack_full) begin
			top_q <= {1'b0, head.num};
		end else if (state_q == S_READ && !(cls_q inside {CL_DIV, CL_REM})) begin
			top_q <= alu_res;
		end else if (state_q == S_DIV && div_rsp.done) begin
			top_q <= (cls_q == CL_DIV) ? div_rsp.quo : div_rsp.rem;
		end
		if (state_q == S_FIN && out_free) begin
			out_q.status       <= fin_status;
			out_q.result_value <= (fin_status == ST_OK) ? $signed(top_q) : 32'sd0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef SYNTHESIS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LW'(STACK_DEPTH))
		else $error("stack level above depth");

	a_div_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> err_q == ST_OK && level_q >= LW'(2))
		else $error("divide running with error or short stack");

	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != ST_OK |-> out_q.result_value == 32'sd0)
		else $error("nonzero value with error status");

	a_spill_level: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> level_q != '0 && level_q < LW'(STACK_DEPTH))
		else $error("stack spill at invalid level");

	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && out_free |=> level_q == '0 && err_q == ST_OK
		&& out_valid_q)
		else $error("expression end did not restart stack");
`endif

endmodule

// ===== test/tb_postfix_expression_evaluator_unit.sv =====
`timescale 1ns / 1ps
// Testbench for postfix_expression_evaluator_unit: sends token requests, predicts each
// expression result with its own stack model and checks every result field by field.
// Depends on pfe_pkg and the postfix_expression_evaluator_unit RTL.
module tb_postfix_expression_evaluator_unit;
	import pfe_pkg::*;

	localparam int DEPTH = DEF_STACK_DEPTH;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 1500;
	localparam int DRAIN_CYCLES = 60;
	localparam int RANDOM_ITEMS = 950;
	localparam int CALM_ITEMS = 250;
	localparam int PRINT_LIMIT = 40;
	localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;
	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] MINUS_ONE = -32'sd1;
	// Codes the block must ignore
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_MID = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic token_valid = 1'b0;
	logic token_ready;
	token_t token_in = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result_out;

	// Expression model state
	logic [31:0] model_stack [DEPTH];
	int unsigned model_level = 0;
	logic [15:0] model_balance = '0;
	logic [2:0] model_error = ST_OK;
	result_t expected_results [$];

	token_t staged [$];
	logic calm = 1'b0;
	int mismatches = 0;
	int tokens_sent = 0;
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	postfix_expression_evaluator_unit #(.STACK_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token(token_in),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result_out)
	);

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_LIMIT) $display("ERROR at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// Keep only the first error of an expression
	function automatic void model_flag(logic [2:0] code);
		if (model_error == ST_OK) model_error = code;
	endfunction

	// Pop right then left operand, push the wrapped result
	function automatic void model_operator(logic [2:0] op);
		logic signed [31:0] lhs, rhs, res;
		logic wraps;
		if (model_level < 2) begin
			model_flag(ST_UNDERFLOW);
			return;
		end
		rhs = model_stack[model_level - 1];
		lhs = model_stack[model_level - 2];
		wraps = (lhs == INT_MIN) && (rhs == MINUS_ONE);
		if ((op == OP_DIV || op == OP_REM) && rhs == 0) begin
			model_flag(ST_DIVZERO);
			return;
		end
		case (op)
		OP_ADD: res = lhs + rhs;
		OP_SUB: res = lhs - rhs;
		OP_MUL: res = lhs * rhs;
		OP_DIV: begin
			if (wraps) res = INT_MIN;
			else res = lhs / rhs;
		end
		default: begin
			if (wraps) res = '0;
			else res = lhs % rhs;
		end
		endcase
		model_level--;
		model_stack[model_level - 1] = res;
	endfunction

	// Advance the model by one accepted token, queue a result on the last one
	function automatic void model_token(token_t t);
		result_t r;
		case (t.kind)
		KIND_NUM: begin
			model_balance++;
			if (model_error == ST_OK) begin
				if (model_level >= DEPTH) model_flag(ST_OVERFLOW);
				else begin
					model_stack[model_level] = {1'b0, t.number_value};
					model_level++;
				end
			end
		end
		KIND_OP: begin
			if (t.operation <= OP_REM) begin
				model_balance--;
				if (model_error == ST_OK) model_operator(t.operation);
			end
		end
		KIND_BRK: begin
			if (model_error == ST_OK && model_level < 2) model_flag(ST_UNDERFLOW);
		end
		default: ;
		endcase
		if (t.last_token) begin
			r = '0;
			if (model_balance != 16'd1) r.status = ST_MISMATCH;
			else if (model_error != ST_OK) r.status = model_error;
			else if (model_level == 0) r.status = ST_UNDERFLOW;
			else begin
				r.status = ST_OK;
				r.result_value = model_stack[model_level - 1];
			end
			expected_results.push_back(r);
			model_level = 0;
			model_balance = '0;
			model_error = ST_OK;
		end
	endfunction

	function automatic token_t make_token(logic [1:0] kind, logic [30:0] num, logic [2:0] op);
		token_t t;
		t.kind = kind;
		t.number_value = num;
		t.operation = op;
		t.last_token = 1'b0;
		return t;
	endfunction

	// Fields a token kind does not use carry random content
	function automatic void stage_number(logic [30:0] v);
		staged.push_back(make_token(KIND_NUM, v, 3'($urandom)));
	endfunction

	function automatic void stage_operator(logic [2:0] op);
		staged.push_back(make_token(KIND_OP, 31'($urandom), op));
	endfunction

	function automatic logic [2:0] pick_operator();
		case ($urandom_range(4))
		0: return OP_ADD;
		1: return OP_SUB;
		2: return OP_MUL;
		3: return OP_DIV;
		default: return OP_REM;
		endcase
	endfunction

	// Stage one operand: a number, or a short subtraction from zero that yields a negative or zero value
	function automatic void stage_operand(int unsigned depth);
		logic [30:0] v;
		int unsigned form;
		case ($urandom_range(9))
		0: v = '0;
		1: v = NUM_MAX;
		2: v = 31'($urandom_range(1, 9));
		3, 4, 5: v = 31'($urandom);
		default: v = 31'($urandom_range(0, 1000));
		endcase
		form = (depth + 2 <= DEPTH) ? $urandom_range(19) : 19;
		if (form < 1) begin
			// most negative value
			stage_number('0);
			stage_number(NUM_MAX);
			stage_operator(OP_SUB);
			stage_number(31'd1);
			stage_operator(OP_SUB);
		end else if (form < 3) begin
			stage_number('0);
			stage_number(31'd1);
			stage_operator(OP_SUB);
		end else if (form < 7) begin
			stage_number('0);
			stage_number(v);
			stage_operator(OP_SUB);
		end else begin
			stage_number(v);
		end
	endfunction

	// Stage a well-formed expression that ends with exactly one value stacked
	function automatic void stage_expression(int unsigned operands, int unsigned max_depth,
			bit brackets);
		int unsigned depth, pushed;
		depth = 0;
		pushed = 0;
		while (pushed < operands || depth > 1) begin
			if (brackets && depth >= 2 && $urandom_range(9) == 0)
				staged.push_back(make_token(KIND_BRK, 31'($urandom), 3'($urandom)));
			if (pushed < operands && (depth < 2 ||
					(depth < max_depth && $urandom_range(1) == 0))) begin
				stage_operand(depth);
				depth++;
				pushed++;
			end else begin
				stage_operator(pick_operator());
				depth--;
			end
		end
	endfunction

	// Offer one token request and wait until it is accepted
	task automatic send_token(input token_t t);
		int unsigned gap;
		gap = 0;
		if (!calm) while ($urandom_range(99) < 32) gap++;
		if (gap != 0) begin
			token_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		token_valid <= 1'b1;
		token_in <= t;
		do @(posedge clk); while (!token_ready);
		model_token(t);
		tokens_sent++;
	endtask

	// Mark the final staged token as last and send the whole expression
	task automatic send_staged();
		staged[staged.size() - 1].last_token = 1'b1;
		foreach (staged[i]) send_token(staged[i]);
		staged.delete();
	endtask

	task automatic send_random_expression();
		int unsigned pick, n;
		token_t t;
		pick = $urandom_range(99);
		if (pick < 8) begin
			// more numbers than the stack holds, balanced by operators
			n = $urandom_range(DEPTH + 1, DEPTH + 4);
			repeat (n) stage_number(31'($urandom));
			repeat (n - 1) stage_operator(pick_operator());
		end else if (pick < 18) begin
			// arbitrary tokens, spare codes included
			n = $urandom_range(1, 8);
			repeat (n) begin
				t = make_token(2'($urandom), 31'($urandom), 3'($urandom));
				t.last_token = ($urandom_range(7) == 0);
				staged.push_back(t);
			end
		end else if (pick < 28) begin
			// well-formed expression with one token dropped or added
			stage_expression($urandom_range(1, 6), DEPTH, 1'b1);
			case ($urandom_range(3))
			0: begin
				if (staged.size() > 1) void'(staged.pop_back());
			end
			1: stage_operator(pick_operator());
			2: staged.push_front(make_token(KIND_BRK, 31'($urandom), 3'($urandom)));
			default: stage_number(31'($urandom));
			endcase
		end else begin
			stage_expression($urandom_range(1, ($urandom_range(3) == 0) ? DEPTH : 5),
				$urandom_range(2, DEPTH), 1'b1);
		end
		send_staged();
	endtask

	// Largest operands, product wraps
	task automatic test_extremes();
		stage_number(NUM_MAX);
		stage_number(NUM_MAX);
		stage_operator(OP_MUL);
		send_staged();
	endtask

	// Most negative value divided by minus one wraps to itself
	task automatic test_divide_wrap();
		stage_number('0);
		stage_number(NUM_MAX);
		stage_operator(OP_SUB);
		stage_number(31'd1);
		stage_operator(OP_SUB);
		stage_number('0);
		stage_number(31'd1);
		stage_operator(OP_SUB);
		stage_operator(OP_DIV);
		send_staged();
	endtask

	// Remainder by zero flags an error and freezes the stack for the add
	task automatic test_divide_by_zero();
		stage_number(31'd5);
		stage_number('0);
		stage_operator(OP_REM);
		stage_number(31'd1);
		stage_operator(OP_ADD);
		send_staged();
	endtask

	// Bracket with one value stacked, then an operator short of operands
	task automatic test_underflow();
		stage_number(31'd1);
		staged.push_back(make_token(KIND_BRK, 31'($urandom), 3'($urandom)));
		stage_number(31'd2);
		stage_operator(OP_ADD);
		send_staged();
		// count mismatch wins over underflow
		stage_number(31'd3);
		stage_operator(OP_ADD);
		send_staged();
	endtask

	// Spare kind and operation codes are skipped, a last mark on one still ends it
	task automatic test_ignored_tokens();
		stage_number(31'd4);
		staged.push_back(make_token(KIND_SPARE, NUM_MAX, OP_SPARE_HI));
		stage_number(31'd3);
		stage_operator(OP_SPARE_LO);
		stage_operator(OP_ADD);
		stage_operator(OP_SPARE_MID);
		stage_operator(OP_SPARE_HI);
		send_staged();
	endtask

	// Hold off results while tokens keep coming so the block fills and stalls
	task automatic test_backpressure();
		hold_requests++;
		repeat (30) begin
			stage_expression($urandom_range(1, 5), 5, 1'b0);
			send_staged();
		end
	endtask

	task automatic test_random_expressions();
		int start;
		start = tokens_sent;
		calm = 1'b1;
		while (tokens_sent - start < RANDOM_ITEMS) begin
			if (tokens_sent - start >= CALM_ITEMS) calm = 1'b0;
			send_random_expression();
		end
	endtask

	// Result side: random stalls, plus a counted hold-off on request
	always @(posedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= calm || ($urandom_range(99) >= 32);
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result value %0d status %0d",
					result_out.result_value, result_out.status));
			end else begin
				want = expected_results.pop_front();
				if (result_out.result_value !== want.result_value)
					report_mismatch($sformatf("result_value %0d, expected %0d",
						result_out.result_value, want.result_value));
				if (result_out.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						result_out.status, want.status));
			end
		end
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((token_valid && token_ready) || (result_valid && result_ready)) stall = 0;
			else stall++;
		end
		$display("postfix_expression_evaluator_unit regression: fail");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_divide_wrap();
		test_divide_by_zero();
		test_underflow();
		test_ignored_tokens();
		test_backpressure();
		test_random_expressions();
		token_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("postfix_expression_evaluator_unit regression: pass");
		end else begin
			$display("postfix_expression_evaluator_unit regression: fail");
		end
		$finish;
	end

endmodule
